// ===== rtl/hue_pkg.sv =====
package hue_pkg;

  localparam int unsigned ModeW      = 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW       = 3;

  localparam logic [ModeW-1:0] MODE_ATTR   = 2'd0;
  localparam logic [ModeW-1:0] MODE_ENTITY = 2'd1;
  localparam logic [ModeW-1:0] MODE_URL    = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_TOP   = 8'h80;

  localparam logic [IdxW-1:0] IDX_LAST_PLAIN = 3'd0;
  localparam logic [IdxW-1:0] IDX_LAST_PCT   = 3'd2;
  localparam logic [IdxW-1:0] IDX_LAST_ENT   = 3'd5;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_PCT   = 2'd1,
    KIND_ENT   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] chr;
    kind_e      kind;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h57 + {4'd0, nib};
    end
    return d;
  endfunction

endpackage

// ===== rtl/hue_front.sv =====
module hue_front
  import hue_pkg::*;
(
  input  logic             start_i,
  input  logic [7:0]       char_byte_i,
  input  logic [ModeW-1:0] escape_mode_i,
  input  logic             full_i,
  output logic             busy_o,
  output push_t            push_o
);

  logic is_alnum;
  logic is_special;
  logic escape;

  always_comb begin
    is_alnum = (char_byte_i >= 8'h30 && char_byte_i <= 8'h39) ||
               (char_byte_i >= 8'h41 && char_byte_i <= 8'h5a) ||
               (char_byte_i >= 8'h61 && char_byte_i <= 8'h7a);
    is_special = (char_byte_i == CH_AMP)  || (char_byte_i == CH_LT)   ||
                 (char_byte_i == CH_GT)   || (char_byte_i == CH_QUOT) ||
                 (char_byte_i == CH_APOS) || (char_byte_i == CH_SLASH);
    priority if (char_byte_i == CH_NUL) begin
      escape = 1'b0;
    end else if (escape_mode_i[1]) begin
      escape = !is_alnum;
    end else if (escape_mode_i == MODE_ENTITY) begin
      escape = is_special;
    end else begin
      escape = ((char_byte_i & CH_TOP) == CH_NUL) && !is_alnum;
    end

    busy_o          = full_i;
    push_o.push     = start_i && !full_i;
    push_o.entry.chr = char_byte_i;
    priority if (!escape) begin
      push_o.entry.kind = KIND_PLAIN;
    end else if (escape_mode_i[1]) begin
      push_o.entry.kind = KIND_PCT;
    end else begin
      push_o.entry.kind = KIND_ENT;
    end
  end

endmodule

// ===== rtl/hue_queue.sv =====
module hue_queue
  import hue_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t             mem_q [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_pop;

  always_comb begin
    full_o   = (count_q == CntW'(QueueDepth));
    empty_o  = (count_q == '0);
    head_o   = mem_q[rd_ptr_q];
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = push_i.push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i.push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CntW'(QueueDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/hue_back.sv =====
module hue_back
  import hue_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  entry_t     head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  entry_t          cur_q, cur_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            active_q, active_d;
  logic            last;

  always_comb begin
    out_byte_o = cur_q.chr;
    last       = 1'b1;
    unique case (cur_q.kind)
      KIND_PLAIN: begin
        out_byte_o = cur_q.chr;
        last       = (idx_q == IDX_LAST_PLAIN);
      end
      KIND_PCT: begin
        last = (idx_q == IDX_LAST_PCT);
        unique case (idx_q)
          3'd0:    out_byte_o = CH_PCT;
          3'd1:    out_byte_o = hex_digit(cur_q.chr[7:4]);
          default: out_byte_o = hex_digit(cur_q.chr[3:0]);
        endcase
      end
      KIND_ENT: begin
        last = (idx_q == IDX_LAST_ENT);
        unique case (idx_q)
          3'd0:    out_byte_o = CH_AMP;
          3'd1:    out_byte_o = CH_HASH;
          3'd2:    out_byte_o = CH_X;
          3'd3:    out_byte_o = hex_digit(cur_q.chr[7:4]);
          3'd4:    out_byte_o = hex_digit(cur_q.chr[3:0]);
          default: out_byte_o = CH_SEMI;
        endcase
      end
      default: begin
        out_byte_o = cur_q.chr;
        last       = 1'b1;
      end
    endcase

    out_valid_o   = active_q;
    last_of_run_o = last;
    pop_o         = !empty_i && (!active_q || last);

    cur_d    = cur_q;
    idx_d    = idx_q;
    active_d = active_q;
    if (pop_o) begin
      cur_d    = head_i;
      idx_d    = '0;
      active_d = 1'b1;
    end else if (active_q && last) begin
      active_d = 1'b0;
    end else if (active_q) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      active_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      active_q <= active_d;
    end
  end

`ifndef SYNTHESIS
  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !last) |=> (active_q && idx_q == $past(idx_q) + 1'b1))
    else $error("escape run broken");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (idx_q <= IDX_LAST_ENT))
    else $error("run index out of range");
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!active_q && !empty_i) |=> (active_q && idx_q == '0))
    else $error("queued beat left waiting");
`endif

endmodule

// ===== rtl/html_url_escape_encoder_core.sv =====
// Escapes a byte stream into HTML hex entities (&#xHH;) or URL percent codes (%HH), one
// output beat per cycle, and passes a zero byte through as the string terminator. A byte
// is taken while busy_o is low; pass-through bytes sustain one per cycle, escaped bytes
// take 3 (URL) or 6 (entity) output beats each, the output emitter writing one beat per
// cycle. The first beat of an item passes through the queue and the emitter's current-entry
// register before it reaches the outputs. busy_o rises when the two-entry queue between
// classifier and emitter is full. Output beats are shown for one cycle under out_valid_o
// and cannot be held off. Write escape_mode only when idle.
module html_url_escape_encoder_core
  import hue_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [7:0]       char_byte_i,
  input  logic             escape_mode_we_i,
  input  logic [ModeW-1:0] escape_mode_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o
);

  logic [ModeW-1:0] mode_q;
  push_t            push;
  logic             full;
  logic             empty;
  logic             pop;
  entry_t           head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ATTR;
    end else if (escape_mode_we_i) begin
      mode_q <= escape_mode_i;
    end
  end

  hue_front u_front (
    .start_i       (start_i),
    .char_byte_i   (char_byte_i),
    .escape_mode_i (mode_q),
    .full_i        (full),
    .busy_o        (busy_o),
    .push_o        (push)
  );

  hue_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  hue_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== bench/html_url_escape_encoder_core_tb.sv =====
`timescale 1ns / 100ps

module html_url_escape_encoder_core_tb;
  import hue_pkg::*;

  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 12;

  typedef struct {
    logic [7:0] chr;
    logic       last;
  } escaped_beat_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [7:0]       char_byte_i;
  logic             escape_mode_we_i;
  logic [ModeW-1:0] escape_mode_i;
  logic             out_valid_o;
  logic [7:0]       out_byte_o;
  logic             last_of_run_o;

  escaped_beat_t    escaped_q[$];
  logic [ModeW-1:0] mode_reg;
  int unsigned      fail_count;
  int unsigned      cycle_count;

  html_url_escape_encoder_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .char_byte_i      (char_byte_i),
    .escape_mode_we_i (escape_mode_we_i),
    .escape_mode_i    (escape_mode_i),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout waiting for escaped output", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit is_alnum(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit is_markup(input logic [7:0] b);
    return b == CH_AMP || b == CH_LT || b == CH_GT || b == CH_QUOT ||
           b == CH_APOS || b == CH_SLASH;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'("0") + 8'(nib) : 8'("a") + 8'(nib) - 8'd10;
  endfunction

  task automatic push_beat(input logic [7:0] chr, input logic last);
    escaped_beat_t e;
    e.chr = chr;
    e.last = last;
    escaped_q.push_back(e);
  endtask

  task automatic predict_escape(input logic [ModeW-1:0] mode, input logic [7:0] b);
    bit esc;
    bit url;
    url = mode[1];
    if (url) begin
      esc = !is_alnum(b);
    end else if (mode == MODE_ENTITY) begin
      esc = is_markup(b);
    end else begin
      esc = (b & CH_TOP) == 8'd0 && !is_alnum(b);
    end
    if (b == CH_NUL || !esc) begin
      push_beat(b, 1'b1);
    end else if (url) begin
      push_beat(CH_PCT, 1'b0);
      push_beat(hex_char(b[7:4]), 1'b0);
      push_beat(hex_char(b[3:0]), 1'b1);
    end else begin
      push_beat(CH_AMP, 1'b0);
      push_beat(CH_HASH, 1'b0);
      push_beat(CH_X, 1'b0);
      push_beat(hex_char(b[7:4]), 1'b0);
      push_beat(hex_char(b[3:0]), 1'b0);
      push_beat(CH_SEMI, 1'b1);
    end
  endtask

  // Check each output beat against the oldest expected one.
  always @(posedge clk_i) begin
    escaped_beat_t e;
    if (rst_ni && out_valid_o) begin
      if (escaped_q.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual byte %h last %b",
                 $time, out_byte_o, last_of_run_o);
        fail_count++;
      end else begin
        e = escaped_q.pop_front();
        if (out_byte_o !== e.chr) begin
          $display("%0t out_byte mismatch: expected %h, actual %h", $time, e.chr, out_byte_o);
          fail_count++;
        end
        if (last_of_run_o !== e.last) begin
          $display("%0t last_of_run mismatch: expected %b, actual %b",
                   $time, e.last, last_of_run_o);
          fail_count++;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return 0;
    end else if (r < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Drive one beat and hold it until taken; start stays high when gap is zero.
  task automatic send_char(input logic [7:0] b, input int unsigned gap);
    start_i <= 1'b1;
    char_byte_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_escape(mode_reg, b);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic set_escape_mode(input logic [ModeW-1:0] mode);
    start_i <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    escape_mode_we_i <= 1'b1;
    escape_mode_i <= mode;
    @(posedge clk_i);
    mode_reg = mode;
    escape_mode_we_i <= 1'b0;
    escape_mode_i <= ModeW'($urandom_range(0, 3));
  endtask

  task automatic send_list(input logic [7:0] chars[]);
    foreach (chars[i]) send_char(chars[i], pick_gap());
    start_i <= 1'b0;
  endtask

  task automatic test_attribute_after_reset();
    send_list('{CH_NUL, 8'h30, 8'h7a, CH_SLASH, CH_TOP, 8'h7f});
  endtask

  task automatic test_entity_markup();
    set_escape_mode(MODE_ENTITY);
    send_list('{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_SLASH, 8'h20});
  endtask

  task automatic test_url_percent();
    set_escape_mode(MODE_URL);
    send_list('{CH_NUL, 8'h39, 8'h41, CH_PCT, 8'hff});
  endtask

  task automatic test_spare_mode();
    set_escape_mode(MODE_SPARE);
    send_list('{8'h2e, 8'h61, CH_NUL});
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] edges[13];
    int unsigned r;
    edges = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_SLASH,
              8'h3a, 8'h40, 8'h5b, 8'h60, 8'h7b, CH_TOP, 8'h7f};
    r = $urandom_range(0, 9);
    if (r < 3) begin
      r = $urandom_range(0, 61);
      if (r < 10) return 8'("0") + 8'(r);
      if (r < 36) return 8'("A") + 8'(r - 10);
      return 8'("a") + 8'(r - 36);
    end else if (r < 5) begin
      return edges[$urandom_range(0, 12)];
    end else if (r == 5) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic test_random_strings();
    int unsigned sent;
    int unsigned len;
    for (int phase = 0; phase < 8; phase++) begin
      set_escape_mode(phase < 4 ? ModeW'(phase) : ModeW'($urandom_range(0, 3)));
      sent = 0;
      while (sent < 50) begin
        len = $urandom_range(0, 12);
        repeat (len) send_char(pick_char(), (phase % 3 == 0) ? 0 : pick_gap());
        send_char(CH_NUL, (phase % 3 == 0) ? 0 : pick_gap());
        sent += len + 1;
      end
      start_i <= 1'b0;
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    char_byte_i <= 8'd0;
    escape_mode_we_i <= 1'b0;
    escape_mode_i <= MODE_ATTR;
    mode_reg = MODE_ATTR;
    fail_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_attribute_after_reset();
    test_entity_markup();
    test_url_percent();
    test_spare_mode();
    test_random_strings();

    start_i <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (escaped_q.size() != 0) begin
      $display("%0t %0d expected beats never arrived", $time, escaped_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== html_url_escape_encoder_core.f =====
rtl/hue_pkg.sv
rtl/hue_front.sv
rtl/hue_queue.sv
rtl/hue_back.sv
rtl/html_url_escape_encoder_core.sv
bench/html_url_escape_encoder_core_tb.sv
